FILE: hdl/bbel_pkg.sv
// ----------------------------------------------------------------------------
// Bethe-Bloch energy loss: shared types and constants
// Request and result structures, fixed-point constants of the medium and the
// status codes used by the pipeline and its checks.
// ----------------------------------------------------------------------------
package bbel_pkg;

	typedef struct packed {
		logic [21:0] momentum_mev;
		logic [19:0] mass_mev;
	} bbel_req_t;

	typedef struct packed {
		logic signed [31:0] energy_loss;
		logic [1:0]         status;
	} bbel_rsp_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// Width of the signed Q32 log-domain values.
	localparam int LOG_W = 44;

	localparam logic [16:0] TWO_ME_Q16  = 17'd66978;
	localparam logic [30:0] ME_SQ_Q32   = 31'd1121513121;
	localparam logic [23:0] LN2_Q24     = 24'd11629080;
	localparam logic [23:0] LOG10_2_Q24 = 24'd5050445;
	localparam logic [21:0] A_Q24       = 22'd3288334;
	localparam logic [28:0] KHALF_Q32   = 29'd329719271;

	localparam logic signed [LOG_W-1:0] C_Q32       = -44'sd22406844383;
	localparam logic signed [LOG_W-1:0] X0_Q32      = 44'sd863288426;
	localparam logic signed [LOG_W-1:0] X1_Q32      = 44'sd12884901888;
	localparam logic signed [LOG_W-1:0] SHIFT16_Q32 = 44'sd68719476736;

	// Same log2 as the hardware unit, evaluated on constants at elaboration.
	function automatic logic [63:0] log2q_const(input logic [63:0] x);
		int          e;
		logic [63:0] y;
		logic [31:0] frac;
		e = 0;
		frac = '0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) begin
				e = i;
			end
		end
		if (e > 31) begin
			y = x >> (e - 31);
		end else begin
			y = x << (31 - e);
		end
		for (int i = 0; i < 32; i++) begin
			y = (y * y) >> 31;
			frac = {frac[30:0], 1'b0};
			if (y[32]) begin
				y = y >> 1;
				frac[0] = 1'b1;
			end
		end
		return {e[31:0], frac};
	endfunction

	// Twice log2 of 2 me / I, in Q32.
	localparam logic [63:0] LOG2_WCONST = log2q_const(64'd10220);
	localparam logic signed [LOG_W-1:0] L2_WCONST_Q32 = $signed(LOG2_WCONST[LOG_W-2:0] << 1);

endpackage

FILE: hdl/bethe_bloch_energy_loss.sv
// ----------------------------------------------------------------------------
// Bethe-Bloch mean energy loss with density correction
// Fully pipelined evaluation of dE/dx for a unit charge in a Z=10, A=20 medium.
// ----------------------------------------------------------------------------
// One request is taken in every cycle while busy is low. The result of a
// request is presented with done high after the chain through the squared
// sum, the 31-stage square root, the 34-stage logarithm units and the final
// multiply stages, with the 61-stage divider for 1/beta^2 running alongside.
// The receiver cannot stall; busy is high only in the first cycle after
// reset.
module bethe_bloch_energy_loss (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bbel_pkg::bbel_req_t req,
	output logic                done,
	output bbel_pkg::bbel_rsp_t rsp
);

	localparam int LW      = bbel_pkg::LOG_W;
	localparam int OUT_STG = 84;
	localparam int PRODX_W = LW + 24;
	localparam int KPROD_W = LW + 29;
	localparam int T_W     = LW - 3;
	localparam int PLO_W   = T_W + 32;
	localparam int PHI_W   = T_W + 29;
	localparam int R_W     = PHI_W + 1;

	logic               busy_q;
	logic               done_q;
	logic [OUT_STG:1]   vld_s;
	bbel_pkg::bbel_rsp_t rsp_q;
	bbel_pkg::bbel_rsp_t rsp_d;

	logic [21:0] p_s1;
	logic [19:0] m_s1;
	logic        zero_c;
	logic [43:0] psq_s2, psq_s3;
	logic [39:0] m2_s2, m2_s3, m2_s35, m2_s36;
	logic [44:0] sum_s3;
	logic [30:0] root_s34;
	logic [31:0] b2_s35, b2_s79;
	logic [60:0] q_s64, q_s82;
	logic [47:0] ep_s35;
	logic [56:0] nd_s36;
	logic [41:0] pm_s36;
	logic        zero_s84;
	logic [37:0] lnd_s70, lm2_s70;
	logic [36:0] lp_s70, lm_s70;

	logic signed [LW-1:0] lbg_s71, ld_s71, la_s72;
	logic [LW-1:0]        lbgm_s72, lam_s73;
	logic                 lbgn_s72, lbgn_s73, lan_s73, lan_s74;
	logic [LW-1:0]        px_s73, pl_s73, lnm_s74;
	logic [PRODX_W-1:0]   prx_c, prl_c, prn_c;
	logic signed [LW-1:0] x_s74, dl_s74, diff_c;
	logic signed [LW-1:0] lnarg_s75, lnarg_s76, lnarg_s77, lnarg_s78, lnarg_s79;
	logic signed [LW-1:0] db_s75, db_s76, db_s77, db_s78;
	logic [17:0]          u_s75, u_s76;
	logic                 le0_s75, le0_s76, le0_s77, le0_s78;
	logic                 le1_s75, le1_s76, le1_s77, le1_s78;
	logic [35:0]          uu_s76;
	logic [53:0]          uuu_s77;
	logic [51:0]          cube_s78;
	logic signed [LW-1:0] delta_s79, br_s80;
	logic [LW-1:0]        bm_s81;
	logic                 neg_s81, neg_s82, neg_s83, neg_s84;
	logic [KPROD_W-1:0]   kp_c;
	logic [T_W-1:0]       t_s82;
	logic [PLO_W-1:0]     plo_s83;
	logic [PHI_W-1:0]     phi_s83;
	logic [R_W-1:0]       r_s84;

	// Control: valid bits travel beside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_s <= '0;
			done_q <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			vld_s <= {vld_s[OUT_STG-1:1], start & ~busy_q};
			done_q <= vld_s[OUT_STG];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	assign zero_c = (p_s1 == '0) || (m_s1 == '0);

	// Front end: squares and their sum.
	always_ff @(posedge clk) begin
		p_s1 <= req.momentum_mev;
		m_s1 <= req.mass_mev;
		psq_s2 <= 44'(p_s1) * 44'(p_s1);
		m2_s2 <= 40'(m_s1) * 40'(m_s1);
		sum_s3 <= 45'(psq_s2) + 45'(m2_s2);
		psq_s3 <= psq_s2;
		m2_s3 <= m2_s2;
	end

	bbel_sqrt #(.RW(31)) u_sqrt (
		.clk  (clk),
		.n    ({1'b0, sum_s3, 16'b0}),
		.root (root_s34)
	);

	bbel_div #(.DEN_W(45), .QUO_W(32)) u_div_beta (
		.clk  (clk),
		.rem0 (45'(psq_s3)),
		.lo   (32'b0),
		.den  (sum_s3),
		.quo  (b2_s35)
	);

	bbel_div #(.DEN_W(44), .QUO_W(61)) u_div_inv (
		.clk  (clk),
		.rem0 (44'b0),
		.lo   ({sum_s3, 16'b0}),
		.den  (psq_s3),
		.quo  (q_s64)
	);

	bbel_delay #(.W(40), .DEPTH(32)) u_dly_m2 (.clk(clk), .d(m2_s3), .q(m2_s35));
	bbel_delay #(.W(42), .DEPTH(35)) u_dly_pm (.clk(clk), .d({p_s1, m_s1}), .q(pm_s36));
	bbel_delay #(.W(1), .DEPTH(83)) u_dly_zero (.clk(clk), .d(zero_c), .q(zero_s84));
	bbel_delay #(.W(32), .DEPTH(44)) u_dly_b2 (.clk(clk), .d(b2_s35), .q(b2_s79));
	bbel_delay #(.W(61), .DEPTH(18)) u_dly_q (.clk(clk), .d(q_s64), .q(q_s82));

	// Denominator of Wmax scaled by M^2: M^2 + 2 me E + me^2.
	always_ff @(posedge clk) begin
		ep_s35 <= 48'(bbel_pkg::TWO_ME_Q16) * 48'(root_s34);
		nd_s36 <= 57'({m2_s35, 16'b0}) + 57'(ep_s35) + 57'(bbel_pkg::ME_SQ_Q32);
		m2_s36 <= m2_s35;
	end

	bbel_log2 #(.IN_W(57)) u_log_nd (.clk(clk), .x(nd_s36), .y_log(lnd_s70));
	bbel_log2 #(.IN_W(40)) u_log_m2 (.clk(clk), .x(m2_s36), .y_log(lm2_s70));
	bbel_log2 #(.IN_W(22)) u_log_p (.clk(clk), .x(pm_s36[41:20]), .y_log(lp_s70));
	bbel_log2 #(.IN_W(20)) u_log_m (.clk(clk), .x(pm_s36[19:0]), .y_log(lm_s70));

	always_comb begin
		prx_c = PRODX_W'(lbgm_s72) * PRODX_W'(bbel_pkg::LOG10_2_Q24);
		prl_c = PRODX_W'(lbgm_s72) * PRODX_W'(bbel_pkg::LN2_Q24);
		prn_c = PRODX_W'(lam_s73) * PRODX_W'(bbel_pkg::LN2_Q24);
		diff_c = bbel_pkg::X1_Q32 - x_s74;
		kp_c = KPROD_W'(bm_s81) * KPROD_W'(bbel_pkg::KHALF_Q32);
	end

	// Log domain: bracket terms and the density correction.
	always_ff @(posedge clk) begin
		lbg_s71 <= $signed(LW'(lp_s70)) - $signed(LW'(lm_s70));
		// log2 of M^2 * 2^16 is log2 of M^2 plus sixteen.
		ld_s71 <= $signed(LW'(lnd_s70)) - $signed(LW'(lm2_s70)) - bbel_pkg::SHIFT16_Q32;

		la_s72 <= (lbg_s71 <<< 2) - ld_s71 + bbel_pkg::L2_WCONST_Q32;
		lbgm_s72 <= lbg_s71[LW-1] ? LW'(-lbg_s71) : LW'(lbg_s71);
		lbgn_s72 <= lbg_s71[LW-1];

		lam_s73 <= la_s72[LW-1] ? LW'(-la_s72) : LW'(la_s72);
		lan_s73 <= la_s72[LW-1];
		px_s73 <= prx_c[LW+23:24];
		pl_s73 <= prl_c[LW+23:24];
		lbgn_s73 <= lbgn_s72;

		x_s74 <= lbgn_s73 ? -$signed(px_s73) : $signed(px_s73);
		dl_s74 <= lbgn_s73 ? -$signed(pl_s73) : $signed(pl_s73);
		lnm_s74 <= prn_c[LW+23:24];
		lan_s74 <= lan_s73;

		lnarg_s75 <= lan_s74 ? -$signed(lnm_s74) : $signed(lnm_s74);
		u_s75 <= diff_c[33:16];
		le0_s75 <= (x_s74 <= bbel_pkg::X0_Q32);
		le1_s75 <= (x_s74 <= bbel_pkg::X1_Q32);
		db_s75 <= (dl_s74 <<< 1) + bbel_pkg::C_Q32;

		uu_s76 <= 36'(u_s75) * 36'(u_s75);
		u_s76 <= u_s75;
		lnarg_s76 <= lnarg_s75;
		db_s76 <= db_s75;
		le0_s76 <= le0_s75;
		le1_s76 <= le1_s75;

		uuu_s77 <= 54'(uu_s76) * 54'(u_s76);
		lnarg_s77 <= lnarg_s76;
		db_s77 <= db_s76;
		le0_s77 <= le0_s76;
		le1_s77 <= le1_s76;

		cube_s78 <= 52'(uuu_s77[53:24]) * 52'(bbel_pkg::A_Q24);
		lnarg_s78 <= lnarg_s77;
		db_s78 <= db_s77;
		le0_s78 <= le0_s77;
		le1_s78 <= le1_s77;

		if (le0_s78) begin
			delta_s79 <= '0;
		end else if (le1_s78) begin
			delta_s79 <= db_s78 + $signed(LW'(cube_s78[51:16]));
		end else begin
			delta_s79 <= db_s78;
		end
		lnarg_s79 <= lnarg_s78;

		br_s80 <= lnarg_s79 - $signed(LW'({b2_s79, 1'b0})) - delta_s79;

		bm_s81 <= br_s80[LW-1] ? LW'(-br_s80) : LW'(br_s80);
		neg_s81 <= br_s80[LW-1];

		t_s82 <= kp_c[KPROD_W-1:32];
		neg_s82 <= neg_s81;

		plo_s83 <= PLO_W'(t_s82) * PLO_W'(q_s82[31:0]);
		phi_s83 <= PHI_W'(t_s82) * PHI_W'(q_s82[60:32]);
		neg_s83 <= neg_s82;

		r_s84 <= R_W'(phi_s83) + R_W'(plo_s83[PLO_W-1:32]);
		neg_s84 <= neg_s83;

		rsp_q <= rsp_d;
	end

	// Sign, saturation and the zero-input case.
	always_comb begin
		rsp_d.energy_loss = '0;
		rsp_d.status = bbel_pkg::ST_OK;
		if (zero_s84) begin
			rsp_d.status = bbel_pkg::ST_ZERO;
		end else if (!neg_s84) begin
			if (r_s84[R_W-1:31] != '0) begin
				rsp_d.energy_loss = 32'sh7FFF_FFFF;
				rsp_d.status = bbel_pkg::ST_SAT;
			end else begin
				rsp_d.energy_loss = $signed(r_s84[31:0]);
			end
		end else begin
			if (r_s84[R_W-1:32] != '0 || (r_s84[31] && r_s84[30:0] != '0)) begin
				rsp_d.energy_loss = 32'sh8000_0000;
				rsp_d.status = bbel_pkg::ST_SAT;
			end else begin
				rsp_d.energy_loss = $signed(~r_s84[31:0] + 32'd1);
			end
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##85 done)
		else $error("accepted request produced no result at the pipeline latency");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == bbel_pkg::ST_ZERO |-> rsp.energy_loss == 32'sd0)
		else $error("zero-input result carries a non-zero energy loss");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == bbel_pkg::ST_SAT |->
		rsp.energy_loss == 32'sh7FFF_FFFF || rsp.energy_loss == 32'sh8000_0000)
		else $error("saturated result is not at a range limit");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status == bbel_pkg::ST_OK || rsp.status == bbel_pkg::ST_ZERO ||
		rsp.status == bbel_pkg::ST_SAT)
		else $error("result carries an unknown status code");

endmodule

FILE: hdl/bbel_delay.sv
// ----------------------------------------------------------------------------
// Bethe-Bloch energy loss: alignment delay line
// Fixed-length register chain that keeps side values in step with the units.
// ----------------------------------------------------------------------------
module bbel_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_s [1:DEPTH];

	always_ff @(posedge clk) begin
		line_s[1] <= d;
		for (int k = 2; k <= DEPTH; k++) begin
			line_s[k] <= line_s[k-1];
		end
	end

	assign q = line_s[DEPTH];

endmodule

FILE: hdl/bbel_sqrt.sv
// ----------------------------------------------------------------------------
// Bethe-Bloch energy loss: pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage, RW stages.
// ----------------------------------------------------------------------------
module bbel_sqrt #(
	parameter int RW = 31
) (
	input  logic            clk,
	input  logic [2*RW-1:0] n,
	output logic [RW-1:0]   root
);

	logic [RW+1:0]   rem_s  [1:RW];
	logic [RW-1:0]   root_s [1:RW];
	logic [2*RW-1:0] nb_s   [1:RW];

	logic [RW+1:0]   rem_in  [0:RW-1];
	logic [RW-1:0]   root_in [0:RW-1];
	logic [2*RW-1:0] nb_in   [0:RW-1];
	logic [RW+1:0]   rem_nx  [0:RW-1];
	logic [RW-1:0]   root_nx [0:RW-1];
	logic [RW+1:0]   cat_c   [0:RW-1];
	logic [RW+1:0]   trial_c [0:RW-1];

	always_comb begin
		rem_in[0] = '0;
		root_in[0] = '0;
		nb_in[0] = n;
		for (int k = 1; k < RW; k++) begin
			rem_in[k] = rem_s[k];
			root_in[k] = root_s[k];
			nb_in[k] = nb_s[k];
		end
		for (int k = 0; k < RW; k++) begin
			cat_c[k] = {rem_in[k][RW-1:0], nb_in[k][2*RW-1:2*RW-2]};
			trial_c[k] = {root_in[k], 2'b01};
			if (cat_c[k] >= trial_c[k]) begin
				rem_nx[k] = cat_c[k] - trial_c[k];
				root_nx[k] = {root_in[k][RW-2:0], 1'b1};
			end else begin
				rem_nx[k] = cat_c[k];
				root_nx[k] = {root_in[k][RW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= RW; k++) begin
			rem_s[k] <= rem_nx[k-1];
			root_s[k] <= root_nx[k-1];
			nb_s[k] <= {nb_in[k-1][2*RW-3:0], 2'b00};
		end
	end

	assign root = root_s[RW];

endmodule

FILE: hdl/bbel_div.sv
// ----------------------------------------------------------------------------
// Bethe-Bloch energy loss: pipelined restoring divider
// Quotient of {rem0, lo} by den, one quotient bit per stage; rem0 < den.
// ----------------------------------------------------------------------------
module bbel_div #(
	parameter int DEN_W = 45,
	parameter int QUO_W = 32
) (
	input  logic             clk,
	input  logic [DEN_W-1:0] rem0,
	input  logic [QUO_W-1:0] lo,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [1:QUO_W];
	logic [QUO_W-1:0] lo_s  [1:QUO_W];
	logic [DEN_W-1:0] den_s [1:QUO_W];
	logic [QUO_W-1:0] quo_s [1:QUO_W];

	logic [DEN_W-1:0] rem_in [0:QUO_W-1];
	logic [QUO_W-1:0] lo_in  [0:QUO_W-1];
	logic [DEN_W-1:0] den_in [0:QUO_W-1];
	logic [QUO_W-1:0] quo_in [0:QUO_W-1];
	logic [DEN_W:0]   cat_c  [0:QUO_W-1];
	logic [DEN_W:0]   diff_c [0:QUO_W-1];
	logic             bit_c  [0:QUO_W-1];

	always_comb begin
		rem_in[0] = rem0;
		lo_in[0] = lo;
		den_in[0] = den;
		quo_in[0] = '0;
		for (int k = 1; k < QUO_W; k++) begin
			rem_in[k] = rem_s[k];
			lo_in[k] = lo_s[k];
			den_in[k] = den_s[k];
			quo_in[k] = quo_s[k];
		end
		for (int k = 0; k < QUO_W; k++) begin
			cat_c[k] = {rem_in[k], lo_in[k][QUO_W-1]};
			diff_c[k] = cat_c[k] - {1'b0, den_in[k]};
			bit_c[k] = (cat_c[k] >= {1'b0, den_in[k]});
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= QUO_W; k++) begin
			rem_s[k] <= bit_c[k-1] ? diff_c[k-1][DEN_W-1:0] : cat_c[k-1][DEN_W-1:0];
			lo_s[k] <= lo_in[k-1] << 1;
			den_s[k] <= den_in[k-1];
			quo_s[k] <= {quo_in[k-1][QUO_W-2:0], bit_c[k-1]};
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

FILE: hdl/bbel_log2.sv
// ----------------------------------------------------------------------------
// Bethe-Bloch energy loss: pipelined base-2 logarithm
// Leading-one search, normalisation, then 32 squaring stages giving one
// fraction bit each. Result is the exponent over a 32-bit fraction.
// ----------------------------------------------------------------------------
module bbel_log2 #(
	parameter int IN_W = 57
) (
	input  logic                         clk,
	input  logic [IN_W-1:0]              x,
	output logic [$clog2(IN_W)+31:0]     y_log
);

	localparam int EW = $clog2(IN_W);

	logic [IN_W-1:0] x_s1;
	logic [EW-1:0]   e_s1;
	logic [EW-1:0]   e_c;
	logic [EW-1:0]   sh_c;
	logic [IN_W+31:0] ext_c;

	logic [31:0]   y_s [0:32];
	logic [31:0]   f_s [0:32];
	logic [EW-1:0] e_s [0:32];
	logic [63:0]   sq_c [1:32];

	always_comb begin
		e_c = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (x[i]) begin
				e_c = EW'(i);
			end
		end
		sh_c = EW'(IN_W - 1) - e_s1;
		ext_c = {x_s1, 32'b0} << sh_c;
		for (int k = 1; k <= 32; k++) begin
			sq_c[k] = 64'(y_s[k-1]) * 64'(y_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x;
		e_s1 <= e_c;
		y_s[0] <= ext_c[IN_W+31 -: 32];
		f_s[0] <= '0;
		e_s[0] <= e_s1;
		for (int k = 1; k <= 32; k++) begin
			// The square of a mantissa in [1,2) lands in [1,4); renormalise.
			y_s[k] <= sq_c[k][63] ? sq_c[k][63:32] : sq_c[k][62:31];
			f_s[k] <= {f_s[k-1][30:0], sq_c[k][63]};
			e_s[k] <= e_s[k-1];
		end
	end

	assign y_log = {e_s[32], f_s[32]};

endmodule

FILE: sim/bbel_checker.sv
// ----------------------------------------------------------------------------
// Bethe-Bloch energy loss: result checker
// Watches accepted requests, computes the expected dE/dx and status for each,
// and compares every result strobe with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module bbel_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  bbel_pkg::bbel_req_t req,
	input  logic                done,
	input  bbel_pkg::bbel_rsp_t rsp,
	output int                  errors,
	output int                  pending
);

	localparam longint unsigned ME_Q16_C    = 64'd33489;
	localparam longint unsigned WCONST      = 64'd10220;
	localparam longint unsigned LN2_C       = 64'd11629080;
	localparam longint unsigned LOG10_2_C   = 64'd5050445;
	localparam longint unsigned CUBE_A      = 64'd3288334;
	localparam longint          DENS_C      = -64'sd22406844383;
	localparam longint          X_LOW       = 64'sd863288426;
	localparam longint          X_HIGH      = 64'sd12884901888;
	localparam longint unsigned STOP_POWER  = 64'd329719271;
	localparam longint unsigned U64_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;

	bbel_pkg::bbel_rsp_t loss_queue[$];

	function automatic longint log2_q32(longint unsigned x);
		int              e;
		longint unsigned y;
		longint unsigned frac;
		e = 63;
		frac = 0;
		if (x == 0) return 0;
		while (x[e] == 1'b0) e--;
		if (e > 31) y = x >> (e - 31);
		else y = x << (31 - e);
		for (int i = 0; i < 32; i++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= (64'd1 << 32)) begin
				y = y >> 1;
				frac = frac | 64'd1;
			end
		end
		return longint'((64'(e) << 32) | frac);
	endfunction

	function automatic longint scale_q24(longint a, longint unsigned c);
		longint unsigned mag;
		longint unsigned prod;
		mag = (a < 0) ? -longint'(a) : a;
		prod = (mag * c) >> 24;
		return (a < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned frac_div(longint unsigned n, longint unsigned d, int f);
		longint unsigned q;
		longint unsigned r;
		q = n / d;
		r = n % d;
		for (int i = 0; i < f; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned add_clamp(longint unsigned x, longint unsigned y);
		return (x > U64_MAX - y) ? U64_MAX : x + y;
	endfunction

	function automatic longint unsigned mul_hi32(longint unsigned a, longint unsigned b);
		longint unsigned hh;
		longint unsigned r;
		hh = (a >> 32) * (b >> 32);
		if (hh >= (64'd1 << 32)) return U64_MAX;
		r = hh << 32;
		r = add_clamp(r, (a & 64'hFFFF_FFFF) * (b >> 32));
		r = add_clamp(r, (a >> 32) * (b & 64'hFFFF_FFFF));
		r = add_clamp(r, ((a & 64'hFFFF_FFFF) * (b & 64'hFFFF_FFFF)) >> 32);
		return r;
	endfunction

	function automatic bbel_pkg::bbel_rsp_t mean_energy_loss(bbel_pkg::bbel_req_t r_in);
		bbel_pkg::bbel_rsp_t res;
		longint unsigned p, m, p2, s, e, msq, nd, b2, q, bmag, t, r;
		longint          lbg, ld, la, lnarg, x, delta, br, u3;
		longint unsigned u;
		p = r_in.momentum_mev;
		m = r_in.mass_mev;
		if (p == 0 || m == 0) begin
			res.energy_loss = '0;
			res.status = bbel_pkg::ST_ZERO;
			return res;
		end
		p2 = p * p;
		s = p2 + m * m;
		e = int_sqrt(s << 16);
		msq = (m * m) << 16;
		nd = msq + 2 * ME_Q16_C * e + ME_Q16_C * ME_Q16_C;
		lbg = log2_q32(p) - log2_q32(m);
		ld = log2_q32(nd) - log2_q32(msq);
		la = 4 * lbg - ld + 2 * log2_q32(WCONST);
		lnarg = scale_q24(la, LN2_C);
		x = scale_q24(lbg, LOG10_2_C);
		if (x <= X_LOW) begin
			delta = 0;
		end else begin
			delta = 2 * scale_q24(lbg, LN2_C) + DENS_C;
			// The cubic term only applies below the upper knee of the correction.
			if (x <= X_HIGH) begin
				u = longint'(X_HIGH - x) >> 16;
				u3 = longint'((((u * u * u) >> 24) * CUBE_A) >> 16);
				delta = delta + u3;
			end
		end
		b2 = frac_div(p2, s, 32);
		br = lnarg - 2 * longint'(b2) - delta;
		bmag = (br < 0) ? -br : br;
		q = frac_div(s, p2, 16);
		t = mul_hi32(bmag, STOP_POWER);
		r = mul_hi32(t, q);
		if (br >= 0) begin
			if (r > 64'h7FFF_FFFF) begin
				res.energy_loss = 32'h7FFF_FFFF;
				res.status = bbel_pkg::ST_SAT;
			end else begin
				res.energy_loss = r[31:0];
				res.status = bbel_pkg::ST_OK;
			end
		end else begin
			if (r > 64'h8000_0000) begin
				res.energy_loss = 32'h8000_0000;
				res.status = bbel_pkg::ST_SAT;
			end else begin
				res.energy_loss = -r[31:0];
				res.status = bbel_pkg::ST_OK;
			end
		end
		return res;
	endfunction

	assign pending = loss_queue.size();

	always @(posedge clk) begin
		bbel_pkg::bbel_rsp_t exp_rsp;
		if (arst_n) begin
			if (done) begin
				if (loss_queue.size() == 0) begin
					$display("%0t: result with no request outstanding: actual %0d/%0d",
						$time, rsp.energy_loss, rsp.status);
					errors++;
				end else begin
					exp_rsp = loss_queue.pop_front();
					if (rsp.energy_loss !== exp_rsp.energy_loss) begin
						$display("%0t: energy_loss expected %0d actual %0d", $time,
							exp_rsp.energy_loss, rsp.energy_loss);
						errors++;
					end
					if (rsp.status !== exp_rsp.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							exp_rsp.status, rsp.status);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				loss_queue.push_back(mean_energy_loss(req));
			end
		end else begin
			errors = 0;
		end
	end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Bethe-Bloch energy loss: testbench top
// Drives directed and random momentum/mass requests in bursts and reports
// the verdict from the checker's mismatch count and outstanding count.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LATENCY = 85;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                done;
	bbel_pkg::bbel_req_t req;
	bbel_pkg::bbel_rsp_t rsp;
	int                  errors;
	int                  pending;

	bethe_bloch_energy_loss uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	bbel_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Present one request and hold it until it is taken.
	task automatic send_request(logic [21:0] p, logic [19:0] m);
		@(negedge clk);
		start <= 1'b1;
		req <= '{momentum_mev: p, mass_mev: m};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Mostly realistic kinematics, with wide-range and raw-bit requests mixed in.
	task automatic random_request();
		logic [21:0] p;
		logic [19:0] m;
		case ($urandom_range(0, 9))
			0: begin
				p = 22'($urandom);
				m = 20'($urandom);
			end
			1: begin
				p = 22'($urandom_range(1, 255));
				m = 20'($urandom_range(1 << 12, 1 << 19));
			end
			2: begin
				p = 22'($urandom_range(1 << 18, 22'h3FFFFF));
				m = 20'($urandom_range(1, 64));
			end
			default: begin
				p = 22'($urandom >> $urandom_range(10, 31));
				m = 20'($urandom >> $urandom_range(12, 31));
			end
		endcase
		send_request(p, m);
	endtask

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(22'd0, 20'd0);
		send_request(22'd0, 20'd35840);
		send_request(22'd1024, 20'd0);
		send_request(22'h3FFFFF, 20'hFFFFF);
		send_request(22'h3FFFFF, 20'd1);
		send_request(22'd1, 20'hFFFFF);
		send_request(22'd1, 20'd1);
		send_request(22'h3FFFFF, 20'd131);
		send_request(22'd25600, 20'd240000);
		send_request(22'd38400, 20'd35720);
		send_request(22'd256000, 20'd35720);
		send_request(22'd2560000, 20'd35720);
		send_request(22'd64, 20'd240000);
		send_request(22'd200, 20'd131);
		send_request(22'h2AAAAA, 20'h55555);
		send_request(22'h155555, 20'hAAAAA);
		pause_sender(3);

		for (int n = 0; n < 1250; ) begin
			int burst;
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++) random_request();
			n += burst;
			if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
		end
		@(negedge clk);
		start <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 10 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
